@@ hw/rtl/escape_sequence_unescaper_defines.svh @@
// Assertion macros shared by the unescaper RTL.
// Depends on nothing; files that use it must have clk and rst_n in scope.
`ifndef ESCAPE_SEQUENCE_UNESCAPER_DEFINES_SVH
`define ESCAPE_SEQUENCE_UNESCAPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ESU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ESU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/esu_pkg.sv @@
// Package for the unescaper: item type, character codes, buffer sizes, drop
// lengths and the hex digit classifier. Depends on nothing.
package esu_pkg;

  localparam int PEND_DEPTH = 12;
  localparam int MAX_EMIT   = 4;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef enum logic [2:0] {
    DROP1,
    DROP2,
    DROP4,
    DROP6,
    DROP12
  } drop_t;

  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_N    = 8'h6E;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_R    = 8'h72;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_SQ   = 8'h27;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_U    = 8'h75;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_NUL  = 8'h00;

  // Returns {valid, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [3:0] drop_len(input drop_t d);
    logic [3:0] r;
    case (d)
      DROP1:   r = 4'd1;
      DROP2:   r = 4'd2;
      DROP4:   r = 4'd4;
      DROP6:   r = 4'd6;
      DROP12:  r = 4'd12;
      default: r = 4'd1;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/esu_fifo.sv @@
// Small register queue used on both sides of the unescaper.
// Depends on nothing.
module esu_fifo #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

@@ hw/rtl/esu_engine.sv @@
// Back end of the unescaper: pending byte buffer, escape decoder and byte
// emitter. Depends on esu_pkg and escape_sequence_unescaper_defines.svh.
`include "escape_sequence_unescaper_defines.svh"

module esu_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_avail,
  input  esu_pkg::item_t in_item,
  output logic          in_take,
  output logic          out_push,
  output esu_pkg::item_t out_item,
  input  logic          out_full
);

  localparam int D = esu_pkg::PEND_DEPTH;

  logic [D-1:0][7:0] pend_r, pend_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic              act_r, act_nxt;
  logic              last_r, last_nxt;
  logic [1:0]        idx_r, idx_nxt;

  logic [4:0]        hx [D];
  logic [2*D-1:0][7:0] ext;
  logic [7:0]        emit_b [esu_pkg::MAX_EMIT];
  logic [2:0]        n_emit;
  esu_pkg::drop_t    drop;
  logic [3:0]        k;
  logic              wait_s, fail, ok_x, ok_u, ok_u2, hi_s, lo_s2, pair_ok;
  logic [7:0]        v_x;
  logic [15:0]       v_u, v_u2;
  logic [20:0]       cp;
  logic              stop, emitting, fin;

  always_comb begin
    for (int i = 0; i < D; i++) begin
      hx[i] = esu_pkg::hex_digit(pend_r[i]);
    end
    ok_x    = hx[2][4] & hx[3][4];
    ok_u    = hx[2][4] & hx[3][4] & hx[4][4] & hx[5][4];
    ok_u2   = hx[8][4] & hx[9][4] & hx[10][4] & hx[11][4];
    v_x     = {hx[2][3:0], hx[3][3:0]};
    v_u     = {hx[2][3:0], hx[3][3:0], hx[4][3:0], hx[5][3:0]};
    v_u2    = {hx[8][3:0], hx[9][3:0], hx[10][3:0], hx[11][3:0]};
    cp      = 21'h10000 + {1'b0, v_u[9:0], v_u2[9:0]};
    hi_s    = (v_u >= 16'hD800) && (v_u <= 16'hDBFF);
    lo_s2   = (v_u2 >= 16'hDC00) && (v_u2 <= 16'hDFFF);
    pair_ok = (pend_r[6] == esu_pkg::CH_BSL) && (pend_r[7] == esu_pkg::CH_U)
              && ok_u2 && lo_s2;

    for (int j = 0; j < esu_pkg::MAX_EMIT; j++) begin
      emit_b[j] = 8'h00;
    end
    n_emit = 3'd1;
    drop   = esu_pkg::DROP1;
    wait_s = 1'b0;
    fail   = 1'b0;

    if (pend_r[0] != esu_pkg::CH_BSL) begin
      emit_b[0] = pend_r[0];
    end else if (cnt_r < 4'd2) begin
      if (!last_r) begin
        wait_s = 1'b1;
      end else begin
        emit_b[0] = esu_pkg::CH_BSL;
      end
    end else begin
      drop = esu_pkg::DROP2;
      case (pend_r[1])
        esu_pkg::CH_N:    emit_b[0] = esu_pkg::CH_LF;
        esu_pkg::CH_T:    emit_b[0] = esu_pkg::CH_TAB;
        esu_pkg::CH_R:    emit_b[0] = esu_pkg::CH_CR;
        esu_pkg::CH_BSL:  emit_b[0] = esu_pkg::CH_BSL;
        esu_pkg::CH_DQ:   emit_b[0] = esu_pkg::CH_DQ;
        esu_pkg::CH_SQ:   emit_b[0] = esu_pkg::CH_SQ;
        esu_pkg::CH_ZERO: emit_b[0] = esu_pkg::CH_NUL;
        esu_pkg::CH_X: begin
          if (cnt_r < 4'd4) begin
            if (!last_r) wait_s = 1'b1;
            else fail = 1'b1;
          end else if (ok_x) begin
            emit_b[0] = v_x;
            drop      = esu_pkg::DROP4;
          end else begin
            fail = 1'b1;
          end
        end
        esu_pkg::CH_U: begin
          if (cnt_r < 4'd6) begin
            if (!last_r) wait_s = 1'b1;
            else fail = 1'b1;
          end else if (!ok_u) begin
            fail = 1'b1;
          end else if (hi_s) begin
            // A high surrogate needs the whole second escape before deciding.
            if (cnt_r < 4'd12) begin
              if (!last_r) wait_s = 1'b1;
              else fail = 1'b1;
            end else if (pair_ok) begin
              emit_b[0] = {5'b11110, cp[20:18]};
              emit_b[1] = {2'b10, cp[17:12]};
              emit_b[2] = {2'b10, cp[11:6]};
              emit_b[3] = {2'b10, cp[5:0]};
              n_emit    = 3'd4;
              drop      = esu_pkg::DROP12;
            end else begin
              fail = 1'b1;
            end
          end else if (v_u < 16'h0080) begin
            emit_b[0] = v_u[7:0];
            drop      = esu_pkg::DROP6;
          end else if (v_u < 16'h0800) begin
            emit_b[0] = {3'b110, v_u[10:6]};
            emit_b[1] = {2'b10, v_u[5:0]};
            n_emit    = 3'd2;
            drop      = esu_pkg::DROP6;
          end else begin
            emit_b[0] = {4'b1110, v_u[15:12]};
            emit_b[1] = {2'b10, v_u[11:6]};
            emit_b[2] = {2'b10, v_u[5:0]};
            n_emit    = 3'd3;
            drop      = esu_pkg::DROP6;
          end
        end
        default: begin
          emit_b[0] = pend_r[0];
          emit_b[1] = pend_r[1];
          n_emit    = 3'd2;
        end
      endcase
      if (fail) begin
        // The backslash goes out alone and the rest is scanned again.
        emit_b[0] = esu_pkg::CH_BSL;
        n_emit    = 3'd1;
        drop      = esu_pkg::DROP1;
      end
    end
  end

  assign k        = esu_pkg::drop_len(drop);
  assign stop     = !act_r || (cnt_r == 4'd0) || wait_s;
  assign emitting = !stop;
  assign fin      = ({1'b0, idx_r} == n_emit - 3'd1);
  assign out_push = emitting && !out_full;
  assign in_take  = stop && in_avail;

  always_comb begin
    out_item.data = emit_b[idx_r];
    // The final byte of a string is the last one of the action that empties
    // the buffer, since every action at the end of a string emits.
    out_item.last = last_r && fin && (cnt_r == k);
  end

  assign ext = {{D{8'h00}}, pend_r};

  always_comb begin
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    act_nxt  = act_r;
    last_nxt = last_r;
    idx_nxt  = idx_r;
    if (stop) begin
      act_nxt = in_avail;
      idx_nxt = 2'd0;
      if (in_avail) begin
        last_nxt = in_item.last;
        cnt_nxt  = cnt_r + 4'd1;
        for (int i = 0; i < D; i++) begin
          if (4'(i) == cnt_r) pend_nxt[i] = in_item.data;
        end
      end
    end else if (out_push) begin
      if (fin) begin
        idx_nxt = 2'd0;
        cnt_nxt = cnt_r - k;
        for (int i = 0; i < D; i++) begin
          case (drop)
            esu_pkg::DROP1:  pend_nxt[i] = ext[5'(i + 1)];
            esu_pkg::DROP2:  pend_nxt[i] = ext[5'(i + 2)];
            esu_pkg::DROP4:  pend_nxt[i] = ext[5'(i + 4)];
            esu_pkg::DROP6:  pend_nxt[i] = ext[5'(i + 6)];
            esu_pkg::DROP12: pend_nxt[i] = ext[5'(i + 12)];
            default:         pend_nxt[i] = pend_r[i];
          endcase
        end
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 4'd0;
      act_r  <= 1'b0;
      last_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      cnt_r  <= cnt_nxt;
      act_r  <= act_nxt;
      last_r <= last_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

  `ESU_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= 4'd12, "pending buffer overran its depth")
  `ESU_ASSERT_IMP(a_idx_bound, emitting, {1'b0, idx_r} < n_emit, "emit index past action")
  `ESU_ASSERT_IMP(a_last_flush, act_r && last_r && stop, cnt_r == 4'd0,
                  "string ended with bytes still pending")
  `ESU_ASSERT_NEXT(a_load_active, in_take, act_r && cnt_r != 4'd0,
                   "loaded item did not start a scan")

endmodule

@@ hw/rtl/escape_sequence_unescaper.sv @@
// An accepted item passes through the input queue and the pending buffer to the result queue.
// The engine takes a new item only while it is not emitting; a failed escape replays
// its held bytes. Outside loads, the decoder emits one byte per cycle from a 12-byte
// pending buffer while the result queue has room.
// Reset (rst_n low, synchronous) empties both queues and the pending buffer.
// Top level: input queue, escape engine and result queue. Depends on esu_pkg,
// esu_fifo and esu_engine.
module escape_sequence_unescaper #(
  parameter int IN_DEPTH  = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last
);

  esu_pkg::item_t in_w, eng_in, eng_out, out_w;
  logic           in_empty, eng_take, eng_push, out_q_full;

  assign in_w.data = in_byte;
  assign in_w.last = in_last;

  esu_fifo #(
    .WIDTH($bits(esu_pkg::item_t)),
    .DEPTH(IN_DEPTH)
  ) u_in_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push),
    .wr_data(in_w),
    .full   (full),
    .rd_en  (eng_take),
    .rd_data(eng_in),
    .empty  (in_empty)
  );

  esu_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_avail(!in_empty),
    .in_item (eng_in),
    .in_take (eng_take),
    .out_push(eng_push),
    .out_item(eng_out),
    .out_full(out_q_full)
  );

  esu_fifo #(
    .WIDTH($bits(esu_pkg::item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (eng_push),
    .wr_data(eng_out),
    .full   (out_q_full),
    .rd_en  (pop),
    .rd_data(out_w),
    .empty  (empty)
  );

  assign out_byte = out_w.data;
  assign out_last = out_w.last;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for escape_sequence_unescaper: directed strings, then
// random escape sequences, checked against a predictor kept inside this file.
// Depends on esu_pkg and the RTL of the block.
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 220;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } out_item_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         known;
    logic [7:0] want;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       out_last;

  // Decoder state kept by the testbench.
  logic [7:0] held[esu_pkg::PEND_DEPTH];
  int         held_cnt;
  out_item_t  decoded_q[$];
  out_item_t  newest;
  int         errors;
  int         cycles;
  int         send_idle;
  int         recv_idle;

  escape_sequence_unescaper dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_byte(in_byte),
    .in_last(in_last), .empty(empty), .pop(pop), .out_byte(out_byte),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // Value of cnt hex digits held from position pos, or -1 if any is not a digit.
  function automatic int held_hex(input int pos, input int cnt);
    int acc;
    int d;
    acc = 0;
    for (int i = 0; i < cnt; i++) begin
      d = nibble_of(held[pos + i]);
      if (d < 0) return -1;
      acc = (acc << 4) | d;
    end
    return acc;
  endfunction

  function automatic void drop_held(input int k);
    if (k >= held_cnt) begin
      held_cnt = 0;
    end else begin
      for (int i = 0; i < held_cnt - k; i++) held[i] = held[i + k];
      held_cnt -= k;
    end
  endfunction

  function automatic void emit_byte(input int b);
    out_item_t o;
    o.data = b[7:0];
    o.last = 1'b0;
    decoded_q.push_back(o);
  endfunction

  // Works out the decoded bytes caused by one accepted raw byte.
  function automatic void unescape_byte(input logic [7:0] b, input logic l);
    int  start;
    int  v;
    int  v2;
    int  cp;
    bit  fail;
    bit  hold;
    start = decoded_q.size();
    if (held_cnt >= esu_pkg::PEND_DEPTH) held_cnt = 0;
    held[held_cnt] = b;
    held_cnt++;
    hold = 1'b0;
    while (held_cnt > 0 && !hold) begin
      fail = 1'b0;
      if (held[0] != esu_pkg::CH_BSL) begin
        emit_byte(held[0]);
        drop_held(1);
      end else if (held_cnt < 2) begin
        if (!l) hold = 1'b1;
        else begin
          emit_byte(esu_pkg::CH_BSL);
          drop_held(1);
        end
      end else begin
        case (held[1])
          esu_pkg::CH_N:    begin emit_byte(esu_pkg::CH_LF);  drop_held(2); end
          esu_pkg::CH_T:    begin emit_byte(esu_pkg::CH_TAB); drop_held(2); end
          esu_pkg::CH_R:    begin emit_byte(esu_pkg::CH_CR);  drop_held(2); end
          esu_pkg::CH_BSL:  begin emit_byte(esu_pkg::CH_BSL); drop_held(2); end
          esu_pkg::CH_DQ:   begin emit_byte(esu_pkg::CH_DQ);  drop_held(2); end
          esu_pkg::CH_SQ:   begin emit_byte(esu_pkg::CH_SQ);  drop_held(2); end
          esu_pkg::CH_ZERO: begin emit_byte(esu_pkg::CH_NUL); drop_held(2); end
          esu_pkg::CH_X: begin
            if (held_cnt < 4) begin
              if (!l) hold = 1'b1;
              else fail = 1'b1;
            end else begin
              v = held_hex(2, 2);
              if (v < 0) fail = 1'b1;
              else begin
                emit_byte(v);
                drop_held(4);
              end
            end
          end
          esu_pkg::CH_U: begin
            if (held_cnt < 6) begin
              if (!l) hold = 1'b1;
              else fail = 1'b1;
            end else begin
              v = held_hex(2, 4);
              if (v < 0) begin
                fail = 1'b1;
              end else if (v >= 'hD800 && v <= 'hDBFF) begin
                if (held_cnt < 12) begin
                  if (!l) hold = 1'b1;
                  else fail = 1'b1;
                end else begin
                  v2 = (held[6] == esu_pkg::CH_BSL && held[7] == esu_pkg::CH_U) ?
                       held_hex(8, 4) : -1;
                  if (v2 >= 'hDC00 && v2 <= 'hDFFF) begin
                    cp = 'h10000 + ((v - 'hD800) << 10) + (v2 - 'hDC00);
                    emit_byte('hF0 | ((cp >> 18) & 'h07));
                    emit_byte('h80 | ((cp >> 12) & 'h3F));
                    emit_byte('h80 | ((cp >> 6) & 'h3F));
                    emit_byte('h80 | (cp & 'h3F));
                    drop_held(12);
                  end else begin
                    fail = 1'b1;
                  end
                end
              end else begin
                if (v < 'h80) begin
                  emit_byte(v);
                end else if (v < 'h800) begin
                  emit_byte('hC0 | (v >> 6));
                  emit_byte('h80 | (v & 'h3F));
                end else begin
                  emit_byte('hE0 | ((v >> 12) & 'h0F));
                  emit_byte('h80 | ((v >> 6) & 'h3F));
                  emit_byte('h80 | (v & 'h3F));
                end
                drop_held(6);
              end
            end
          end
          default: begin
            emit_byte(held[0]);
            emit_byte(held[1]);
            drop_held(2);
          end
        endcase
        if (fail) begin
          emit_byte(esu_pkg::CH_BSL);
          drop_held(1);
        end
      end
    end
    if (l) begin
      held_cnt = 0;
      if (decoded_q.size() > start) decoded_q[decoded_q.size() - 1].last = 1'b1;
    end
    if (decoded_q.size() > start) newest = decoded_q[decoded_q.size() - 1];
  endfunction

  // Results are compared before the item accepted at the same edge is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          report($sformatf("unexpected item %02h last %0b", out_byte, out_last));
        end else begin
          if (out_byte !== decoded_q[0].data)
            report($sformatf("byte %02h, wanted %02h", out_byte, decoded_q[0].data));
          if (out_last !== decoded_q[0].last)
            report($sformatf("last %0b, wanted %0b", out_last, decoded_q[0].last));
          void'(decoded_q.pop_front());
        end
      end
      if (push && !full) unescape_byte(in_byte, in_last);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop = rst_n && ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    in_byte = b;
    in_last = l;
    do @(posedge clk); while (full !== 1'b0);
    @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return "0" + n;
    return 8'(($urandom_range(1) ? "a" : "A") + n - 10);
  endfunction

  // Queues the raw bytes of one random escape sequence or plain byte.
  function automatic void make_sequence(ref logic [7:0] raw[$]);
    logic [7:0] simple[7];
    logic [15:0] code;
    int kind;
    simple = '{esu_pkg::CH_N, esu_pkg::CH_T, esu_pkg::CH_R, esu_pkg::CH_BSL,
               esu_pkg::CH_DQ, esu_pkg::CH_SQ, esu_pkg::CH_ZERO};
    kind = $urandom_range(9);
    case (kind)
      0, 1: raw.push_back(8'($urandom_range(255)));
      2: begin
        raw.push_back(esu_pkg::CH_BSL);
        raw.push_back(simple[$urandom_range(6)]);
      end
      3: begin
        raw.push_back(esu_pkg::CH_BSL);
        raw.push_back(8'($urandom_range(255)));
      end
      4: begin
        raw.push_back(esu_pkg::CH_BSL);
        raw.push_back(esu_pkg::CH_X);
        raw.push_back(hex_char(4'($urandom_range(15))));
        raw.push_back($urandom_range(3) == 0 ? 8'($urandom_range(255)) :
                      hex_char(4'($urandom_range(15))));
      end
      5, 6: begin
        code = 16'($urandom_range(65535));
        if (code >= 16'hD800 && code <= 16'hDBFF && $urandom_range(3) != 0) code[15] = 1'b0;
        if ($urandom_range(2) == 0) code = 16'($urandom_range(16'h7FF));
        raw.push_back(esu_pkg::CH_BSL);
        raw.push_back(esu_pkg::CH_U);
        for (int i = 3; i >= 0; i--) raw.push_back(hex_char(code[i*4 +: 4]));
      end
      7, 8: begin
        code = 16'hD800 + 16'($urandom_range(16'h3FF));
        raw.push_back(esu_pkg::CH_BSL);
        raw.push_back(esu_pkg::CH_U);
        for (int i = 3; i >= 0; i--) raw.push_back(hex_char(code[i*4 +: 4]));
        code = 16'hDC00 + 16'($urandom_range(16'h3FF));
        if (kind == 8 && $urandom_range(1)) code = 16'($urandom_range(65535));
        raw.push_back(esu_pkg::CH_BSL);
        raw.push_back(kind == 8 && $urandom_range(3) == 0 ? esu_pkg::CH_X : esu_pkg::CH_U);
        for (int i = 3; i >= 0; i--) raw.push_back(hex_char(code[i*4 +: 4]));
      end
      default: begin
        // Backslash followed by a run of noise, often a broken escape.
        raw.push_back(esu_pkg::CH_BSL);
        raw.push_back($urandom_range(1) ? esu_pkg::CH_U : esu_pkg::CH_X);
        for (int i = $urandom_range(3); i > 0; i--) raw.push_back(8'($urandom_range(255)));
      end
    endcase
  endfunction

  initial begin
    stim_row_t  rows[];
    logic [7:0] raw[$];
    int         sent;
    int         waited;
    rows = '{
      '{8'h00, 1'b0, 1'b1, 8'h00},
      '{8'hFF, 1'b0, 1'b1, 8'hFF},
      '{esu_pkg::CH_BSL, 1'b0, 1'b0, 8'h00},
      '{esu_pkg::CH_N, 1'b0, 1'b1, esu_pkg::CH_LF},
      '{esu_pkg::CH_BSL, 1'b0, 1'b0, 8'h00},
      '{esu_pkg::CH_ZERO, 1'b0, 1'b1, esu_pkg::CH_NUL},
      '{esu_pkg::CH_BSL, 1'b0, 1'b0, 8'h00},
      '{esu_pkg::CH_X, 1'b0, 1'b0, 8'h00},
      '{"4", 1'b0, 1'b0, 8'h00},
      '{"1", 1'b0, 1'b1, "A"},
      '{esu_pkg::CH_BSL, 1'b0, 1'b0, 8'h00},
      '{"q", 1'b0, 1'b0, 8'h00},
      '{esu_pkg::CH_BSL, 1'b0, 1'b0, 8'h00},
      '{esu_pkg::CH_U, 1'b0, 1'b0, 8'h00},
      '{"2", 1'b0, 1'b0, 8'h00},
      '{"0", 1'b0, 1'b0, 8'h00},
      '{"a", 1'b0, 1'b0, 8'h00},
      '{"C", 1'b0, 1'b0, 8'h00},
      '{esu_pkg::CH_BSL, 1'b0, 1'b0, 8'h00},
      '{esu_pkg::CH_X, 1'b0, 1'b0, 8'h00},
      '{"G", 1'b0, 1'b0, 8'h00},
      '{esu_pkg::CH_BSL, 1'b1, 1'b1, esu_pkg::CH_BSL},
      '{esu_pkg::CH_BSL, 1'b0, 1'b0, 8'h00},
      '{esu_pkg::CH_X, 1'b0, 1'b0, 8'h00},
      '{"4", 1'b1, 1'b0, 8'h00}
    };
    errors = 0;
    held_cnt = 0;
    send_idle = 10;
    recv_idle = 88;
    rst_n = 1'b0;
    push = 1'b0;
    in_byte = 8'h00;
    in_last = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      send(rows[i].data, rows[i].last);
      if (rows[i].known && newest.data !== rows[i].want)
        report($sformatf("directed row %0d decodes to %02h, wanted %02h", i, newest.data,
                         rows[i].want));
    end

    // Hold the sender off until the block has drained.
    push = 1'b0;
    wait (decoded_q.size() == 0);
    @(negedge clk);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // Sequences vary in length, so the phase changes once a threshold is passed.
      if (sent >= RANDOM_ITEMS / 3 && send_idle == 10) begin
        send_idle = 88;
        recv_idle = 10;
      end else if (sent >= 2 * RANDOM_ITEMS / 3 && send_idle == 88) begin
        send_idle = 0;
        recv_idle = 0;
      end
      make_sequence(raw);
      while (raw.size() > 0) begin
        send(raw[0], raw.size() == 1 ? ($urandom_range(5) == 0) : ($urandom_range(40) == 0));
        void'(raw.pop_front());
        sent++;
      end
    end
    send(8'h2E, 1'b1);
    push = 1'b0;

    waited = 0;
    while (decoded_q.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (40) @(negedge clk);
    if (decoded_q.size() != 0)
      report($sformatf("%0d decoded items never arrived", decoded_q.size()));
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/esu_pkg.sv
hw/rtl/esu_fifo.sv
hw/rtl/esu_engine.sv
hw/rtl/escape_sequence_unescaper.sv
tb/testbench.sv
